// ===== design/shrng_pkg.sv =====
// Shared types and constants for the shuffled minimal standard generator.
`default_nettype none
package shrng_pkg;

  localparam logic [14:0] LCG_MULT     = 15'd16807;
  localparam logic [31:0] LCG_MOD      = 32'h7FFF_FFFF;
  localparam logic [30:0] CLIP_LEVEL   = 31'd2147483390;
  localparam int          WARMUP_STEPS = 8;

  typedef struct packed {
    logic load_seed;   // load generator start value from seed
    logic mul;         // register generator product
    logic red;         // reduce product modulo 2^31-1 into generator
    logic fill;        // table write of reduced value during initialization
    logic set_last;    // last output from generator value
    logic pick;        // register table slot of last output
    logic rd;          // table read at slot
    logic fin;         // refill slot, publish result
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/shrng_dp.sv =====
// Datapath: generator, shuffle table, slot select and result register.
`default_nettype none
module shrng_dp #(
  parameter int TABLE_SIZE = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic signed [31:0] cfg_data,
  input  wire shrng_pkg::dp_cmd_t cmd,
  output shrng_pkg::dp_sts_t      sts,
  output logic [30:0]             out_value,
  output logic                    out_clipped
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + shrng_pkg::WARMUP_STEPS);
  localparam int SLOT_DIV = 1 + (2147483646 / TABLE_SIZE);
  localparam logic [CW-1:0] CNT_INIT = CW'(TABLE_SIZE + shrng_pkg::WARMUP_STEPS - 1);
  localparam logic [CW-1:0] CNT_FILL = CW'(TABLE_SIZE);

  logic [31:0]   seed_r;
  logic [30:0]   x_r;
  logic [45:0]   p_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] q_r;
  logic [30:0]   last_r;
  logic [30:0]   rdata_r;
  logic [30:0]   out_value_r;
  logic          out_clipped_r;
  logic [30:0]   mem [TABLE_SIZE];

  logic [31:0]   mag;
  logic [31:0]   mag_red;
  logic [30:0]   start;
  logic [31:0]   sum;
  logic [31:0]   sum_sub;
  logic [30:0]   red_val;
  logic [IW-1:0] slot;
  logic          cnt_fill;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [30:0]   wr_data;

  always_comb begin
    mag     = ~seed_r + 32'd1;
    mag_red = (mag >= shrng_pkg::LCG_MOD) ? (mag - shrng_pkg::LCG_MOD) : mag;
    start   = (!seed_r[31] || (mag_red == 32'd0)) ? 31'd1 : mag_red[30:0];

    sum     = {1'b0, p_r[30:0]} + {17'd0, p_r[45:31]};
    sum_sub = sum - shrng_pkg::LCG_MOD;
    red_val = (sum >= shrng_pkg::LCG_MOD) ? sum_sub[30:0] : sum[30:0];

    // slot = last / SLOT_DIV: highest constant multiple not above last
    slot = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if (last_r >= 31'(k * SLOT_DIV)) begin
        slot = IW'(k);
      end
    end

    cnt_fill = (cnt_r < CNT_FILL);
    wr_en    = cmd.fin || (cmd.fill && cnt_fill);
    wr_addr  = cmd.fin ? q_r : cnt_r[IW-1:0];
    wr_data  = cmd.fin ? x_r : red_val;
  end

  assign sts.cnt_zero = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      x_r   <= start;
      cnt_r <= CNT_INIT;
    end
    if (cmd.mul) begin
      p_r <= 46'(x_r) * 46'(shrng_pkg::LCG_MULT);
    end
    if (cmd.red) begin
      x_r <= red_val;
    end
    if (cmd.fill && !sts.cnt_zero) begin
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.pick) begin
      q_r <= slot;
    end
    if (cmd.set_last) begin
      last_r <= x_r;
    end
    if (cmd.fin) begin
      last_r        <= rdata_r;
      out_value_r   <= rdata_r;
      out_clipped_r <= (rdata_r >= shrng_pkg::CLIP_LEVEL);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= mem[q_r];
    end
  end

  assign out_value   = out_value_r;
  assign out_clipped = out_clipped_r;

endmodule
`default_nettype wire

// ===== design/shrng_ctrl.sv =====
// Controller: sequences initialization, draw steps and the result handshake.
`default_nettype none
module shrng_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire shrng_pkg::dp_sts_t sts,
  output shrng_pkg::dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_I_LOAD,
    ST_I_MUL,
    ST_I_RED,
    ST_I_LAST,
    ST_D_MUL,
    ST_D_RED,
    ST_D_RD,
    ST_D_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   init_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_restart || !init_r) ? ST_I_LOAD : ST_D_MUL;
        end
      end
      ST_I_LOAD: begin
        cmd.load_seed = 1'b1;
        state_nxt     = ST_I_MUL;
      end
      ST_I_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_I_RED;
      end
      ST_I_RED: begin
        cmd.red   = 1'b1;
        cmd.fill  = 1'b1;
        state_nxt = sts.cnt_zero ? ST_I_LAST : ST_I_MUL;
      end
      ST_I_LAST: begin
        cmd.set_last = 1'b1;
        state_nxt    = ST_D_MUL;
      end
      ST_D_MUL: begin
        cmd.mul   = 1'b1;
        cmd.pick  = 1'b1;
        state_nxt = ST_D_RED;
      end
      ST_D_RED: begin
        cmd.red   = 1'b1;
        state_nxt = ST_D_RD;
      end
      ST_D_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_D_FIN;
      end
      ST_D_FIN: begin
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_I_LAST) begin
        init_r <= 1'b1;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("transfer accepted but controller stayed idle");

  a_draw_needs_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D_MUL) |-> (init_r || $past(state_r) == ST_I_LAST))
    else $error("draw started before table fill");

  a_fin_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("finished draw did not raise out_valid");

  a_fin_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> out_free)
    else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

// ===== design/shuffled_minimal_standard_rng_top.sv =====
// Draw: after the in_valid transfer the controller runs multiply and slot pick, reduce and
// table read, then refill and publish, which raises out_valid; publishing waits while
// out_valid is high and out_ready is low. A new draw is taken in idle, once the previous
// one has left the controller. Initialization (first draw after reset or restart) runs first:
// seed load, then multiply and reduce for each of TABLE_SIZE+8 steps, then last-output setup.
// Reset is synchronous; seed returns to -1 and the next draw reinitializes.
`default_nettype none
module shuffled_minimal_standard_rng_top #(
  parameter int TABLE_SIZE = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [31:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [30:0]             out_value,
  output logic                    out_clipped
);

  shrng_pkg::dp_cmd_t cmd;
  shrng_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  shrng_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  shrng_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_value   (out_value),
    .out_clipped (out_clipped)
  );

endmodule
`default_nettype wire
